// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/xfr_pkg.sv =====
// Shared types and constants of the XOR frame receiver.
package xfr_pkg;

  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
  localparam logic [8:0] POS_MAX        = 9'd511;
  localparam logic [8:0] HDR_BYTES      = 9'd3;   // sender, length, receiver
  localparam logic [7:0] HDR_EXTRA      = 8'd2;
  localparam logic [8:0] MIN_LAST_POS   = 9'd3;   // a 4-byte frame ends at position 3

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic       is_payload;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_end;
    logic       frame_ok;
    logic       for_us;
    logic [7:0] frame_sender;
    logic [7:0] frame_receiver;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ===== sv/xfr_frame_state.sv =====
// Per-byte frame tracking: header capture, running XOR and result decode.
module xfr_frame_state import xfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic       end_of_frame,
  input  logic [7:0] own_address,
  output result_t    result
);

  logic [8:0] byte_position;
  logic [7:0] running_xor;
  logic [7:0] sender_held;
  logic [7:0] length_held;
  logic [7:0] receiver_held;

  logic [7:0] snd;
  logic [7:0] len;
  logic [7:0] rcv;
  logic       pay;

  always_comb begin
    snd = sender_held;
    len = length_held;
    rcv = receiver_held;
    case (byte_position)
      9'd0:    snd = rx_byte;
      9'd1:    len = rx_byte;
      9'd2:    rcv = rx_byte;
      default: ;
    endcase
  end

  assign pay = (byte_position >= HDR_BYTES) && (byte_position <= {1'b0, len});

  always_comb begin
    result.is_payload     = pay;
    result.payload_byte   = pay ? rx_byte : 8'd0;
    result.payload_index  = pay ? (byte_position[7:0] - HDR_BYTES[7:0]) : 8'd0;
    result.frame_end      = end_of_frame;
    result.payload_length = (len >= HDR_EXTRA) ? (len - HDR_EXTRA) : 8'd0;
    // Count check: length field == (position + 1) - 2, with position >= 3.
    result.frame_ok       = end_of_frame && (byte_position >= MIN_LAST_POS) &&
                            ({1'b0, len} == (byte_position - 9'd1)) &&
                            (running_xor == rx_byte);
    result.for_us         = end_of_frame &&
                            ((rcv == own_address) || (rcv == BROADCAST_ADDR));
    result.frame_sender   = end_of_frame ? snd : 8'd0;
    result.frame_receiver = end_of_frame ? rcv : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_xor   <= '0;
      sender_held   <= '0;
      length_held   <= '0;
      receiver_held <= '0;
    end else if (fire) begin
      if (end_of_frame) begin
        byte_position <= '0;
        running_xor   <= '0;
        sender_held   <= '0;
        length_held   <= '0;
        receiver_held <= '0;
      end else begin
        sender_held   <= snd;
        length_held   <= len;
        receiver_held <= rcv;
        running_xor   <= running_xor ^ rx_byte;
        byte_position <= (byte_position < POS_MAX) ? (byte_position + 9'd1) : POS_MAX;
      end
    end
  end

endmodule

// ===== sv/xfr_out_skid.sv =====
// Two-entry output stage: result register plus skid register.
module xfr_out_skid import xfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== sv/xor_frame_receiver.sv =====
// Top level of the XOR-checksummed frame receiver.
// The result of each accepted input beat is registered in the output stage before the master side sees it.
// Throughput: one beat per cycle while s_tready is high; header capture, XOR and checks are combinational.
// A two-entry output stage keeps s_tready high for one more beat while a result waits.
// Reset (rst, synchronous): clears frame position, running XOR, held header bytes,
// own address and both output entries; the block is ready in the cycle after reset.
module xor_frame_receiver import xfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: own address
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  // Slave side: received bytes
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  input  logic                   s_tlast,   // end_of_frame
  // Master side: one result beat per input beat
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] payload_byte, [15:8] payload_index, [16] frame_ok, [17] for_us,
  // [25:18] frame_sender, [33:26] frame_receiver, [41:34] payload_length, [47:42] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // is_payload
  output logic                   m_tlast    // frame_end
);

  logic [7:0] own_address;
  logic       in_fire;
  result_t    step_result;
  result_t    out_result;

  // Hold the node address; it is to be written only while idle, a rule on the user that the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  assign in_fire = s_tvalid && s_tready;

  // Decode each byte against the frame state and advance it on every accepted beat.
  xfr_frame_state u_state (
    .clk          (clk),
    .rst          (rst),
    .fire         (in_fire),
    .rx_byte      (s_tdata[7:0]),
    .end_of_frame (s_tlast),
    .own_address  (own_address),
    .result       (step_result)
  );

  // Register the result; the skid entry absorbs one beat of back-pressure.
  xfr_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  // Pack the result fields, lowest first, and pad to whole bytes.
  assign m_tdata = {6'd0,
                    out_result.payload_length,
                    out_result.frame_receiver,
                    out_result.frame_sender,
                    out_result.for_us,
                    out_result.frame_ok,
                    out_result.payload_index,
                    out_result.payload_byte};
  assign m_tuser = out_result.is_payload;
  assign m_tlast = out_result.frame_end;

endmodule

// ===== sv/xfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`include "assert_macros.svh"

module xfr_checker import xfr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  logic stalled;
  logic nonpay_beat;
  logic midframe_beat;
  logic pay_fields_set;
  logic report_fields_set;

  assign stalled           = m_tvalid && !m_tready;
  assign nonpay_beat       = m_tvalid && !m_tuser;
  assign midframe_beat     = m_tvalid && !m_tlast;
  assign pay_fields_set    = |m_tdata[15:0];
  assign report_fields_set = |m_tdata[33:16];

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "output valid right after reset")
  `ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_tvalid, "result beat dropped while stalled")
  `ASSERT_IMPLY(a_nonpay_zero, clk, rst, nonpay_beat, !pay_fields_set, "stray payload fields")
  `ASSERT_IMPLY(a_mid_zero, clk, rst, midframe_beat, !report_fields_set, "early frame report")

endmodule

bind xor_frame_receiver xfr_checker u_xfr_checker (.*);
